// ===== rtl/kwm_pkg.sv =====
// kwm_pkg: shared constants for the k-way sorted merge block
`default_nettype none

package kwm_pkg;

   // operation codes carried by req_op
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // fixed field widths
   localparam int VALUE_W = 32;
   localparam int SEL_W   = 3;

endpackage

`default_nettype wire

// ===== rtl/k_way_sorted_merge.sv =====
// k_way_sorted_merge: k-way merge of ascending lists held in list FIFOs in one memory
//
//   channel | direction | fields
//   req_    | in        | op, list_sel, value
//   rsp_    | out       | out_value, out_list, out_valid, overflow
//
// A push reads the list's pointer entry, then writes the value.
// A pop reads the pointer memory and the value memory once per list, one list per cycle
// through a two-stage read pipeline, then writes the winner's pointers back. Reset is
// synchronous; the pointer entries start empty through one valid bit per list. A stalled
// rsp_ channel holds the block in its last step.
`default_nettype none

module k_way_sorted_merge #(
   parameter int LISTS      = 8,
   parameter int LIST_DEPTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_op,
   input  wire logic [kwm_pkg::SEL_W-1:0]        req_list_sel,
   input  wire logic signed [kwm_pkg::VALUE_W-1:0] req_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [kwm_pkg::VALUE_W-1:0]    rsp_out_value,
   output logic [kwm_pkg::SEL_W-1:0]             rsp_out_list,
   output logic                                  rsp_out_valid,
   output logic                                  rsp_overflow
);

   localparam int LW          = $clog2(LISTS);
   localparam int PW          = $clog2(LIST_DEPTH);
   localparam int CW          = $clog2(LIST_DEPTH + 1);
   localparam int STORE_DEPTH = LISTS * LIST_DEPTH;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int MW          = PW + PW + CW;
   localparam int VW          = kwm_pkg::VALUE_W;

   // state codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PUSH = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_WAIT = 2'd3;

   logic [1:0]    state_ff, state_in;

   // captured transaction
   logic [LW-1:0] list_ff;
   logic          bad_ff;
   logic [VW-1:0] val_ff;

   // memories
   logic [VW-1:0] store_mem [STORE_DEPTH];
   logic [MW-1:0] meta_mem  [LISTS];
   logic [LISTS-1:0] meta_vld_ff;

   logic [VW-1:0] st_q_ff;
   logic [MW-1:0] meta_q_ff;
   logic          meta_qv_ff;

   logic          st_we;
   logic [AW-1:0] st_waddr, st_raddr;
   logic          meta_we;
   logic [LW-1:0] meta_waddr, meta_raddr;
   logic [MW-1:0] meta_wdata;

   // scan pipeline
   logic [LW-1:0] scan_ff;
   logic          s1_vld_ff;
   logic [LW-1:0] s1_idx_ff;
   logic          s2_vld_ff;
   logic [LW-1:0] s2_idx_ff;
   logic [MW-1:0] s2_meta_ff;

   // running best
   logic          found_ff;
   logic [LW-1:0] best_idx_ff;
   logic [VW-1:0] best_val_ff;
   logic [MW-1:0] best_meta_ff;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_value_ff;
   logic [kwm_pkg::SEL_W-1:0] rsp_list_ff;
   logic          rsp_ok_ff;
   logic          rsp_ovf_ff;

   logic          accept;
   logic          out_free;
   logic          fin_push;
   logic          fin_pop;
   logic          push_full;
   logic [MW-1:0] m1;
   logic [PW-1:0] m1_head;
   logic [PW-1:0] m1_tail;
   logic [CW-1:0] m1_cnt;
   logic [PW-1:0] b_head;
   logic [PW-1:0] b_tail;
   logic [CW-1:0] b_cnt;
   logic [CW-1:0] s2_cnt;
   logic          take;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // meta read data, empty when the entry was never written
   assign m1      = meta_qv_ff ? meta_q_ff : '0;
   assign m1_head = m1[MW-1 -: PW];
   assign m1_tail = m1[CW +: PW];
   assign m1_cnt  = m1[CW-1:0];
   assign b_head  = best_meta_ff[MW-1 -: PW];
   assign b_tail  = best_meta_ff[CW +: PW];
   assign b_cnt   = best_meta_ff[CW-1:0];
   assign s2_cnt  = s2_meta_ff[CW-1:0];

   assign push_full = bad_ff || (m1_cnt == CW'(LIST_DEPTH));
   assign fin_push  = (state_ff == ST_PUSH) && out_free;
   assign fin_pop   = (state_ff == ST_WAIT) && !s1_vld_ff && !s2_vld_ff && out_free;

   // compare stage: strict less keeps the lowest list on ties
   assign take = s2_vld_ff && (s2_cnt != '0) &&
                 (!found_ff || ($signed(st_q_ff) < $signed(best_val_ff)));

   // controller
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_op == kwm_pkg::OP_POP) ? ST_SCAN : ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_ff == LW'(LISTS - 1)) state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (fin_pop) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // transaction capture
   always_ff @(posedge clock) begin
      if (accept) begin
         list_ff <= LW'(req_list_sel);
         bad_ff  <= (int'(req_list_sel) >= LISTS);
         val_ff  <= req_value;
      end
   end

   // memory addressing
   always_comb begin
      unique case (state_ff)
         ST_IDLE: meta_raddr = LW'(req_list_sel);
         ST_PUSH: meta_raddr = list_ff;
         default: meta_raddr = scan_ff;
      endcase
   end

   assign st_raddr = AW'(s1_idx_ff) * AW'(LIST_DEPTH) + AW'(m1_head);
   assign st_we    = fin_push && !push_full;
   assign st_waddr = AW'(list_ff) * AW'(LIST_DEPTH) + AW'(m1_tail);

   always_comb begin
      meta_we    = 1'b0;
      meta_waddr = list_ff;
      meta_wdata = m1;
      if (st_we) begin
         meta_we    = 1'b1;
         meta_waddr = list_ff;
         meta_wdata = {m1_head,
                       (m1_tail == PW'(LIST_DEPTH - 1)) ? PW'(0) : m1_tail + PW'(1),
                       m1_cnt + CW'(1)};
      end else if (fin_pop && found_ff) begin
         meta_we    = 1'b1;
         meta_waddr = best_idx_ff;
         meta_wdata = {(b_head == PW'(LIST_DEPTH - 1)) ? PW'(0) : b_head + PW'(1),
                       b_tail,
                       b_cnt - CW'(1)};
      end
   end

   // value memory
   always_ff @(posedge clock) begin
      if (st_we) store_mem[st_waddr] <= val_ff;
      st_q_ff <= store_mem[st_raddr];
   end

   // pointer memory
   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
      meta_q_ff <= meta_mem[meta_raddr];
   end

   // pointer entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         meta_vld_ff <= '0;
         meta_qv_ff  <= 1'b0;
      end else begin
         if (meta_we) meta_vld_ff[meta_waddr] <= 1'b1;
         meta_qv_ff <= meta_vld_ff[meta_raddr];
      end
   end

   // scan pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff   <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         s1_vld_ff <= (state_ff == ST_SCAN);
         s2_vld_ff <= s1_vld_ff;
         if (state_ff == ST_SCAN) begin
            scan_ff <= (scan_ff == LW'(LISTS - 1)) ? '0 : scan_ff + LW'(1);
         end
         if (accept) begin
            found_ff <= 1'b0;
         end else if (take) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff  <= scan_ff;
      s2_idx_ff  <= s1_idx_ff;
      s2_meta_ff <= m1;
      if (take) begin
         best_idx_ff  <= s2_idx_ff;
         best_val_ff  <= st_q_ff;
         best_meta_ff <= s2_meta_ff;
      end
   end

   // output register
   assign rsp_valid_in = fin_push || fin_pop || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_push) begin
         rsp_value_ff <= '0;
         rsp_list_ff  <= '0;
         rsp_ok_ff    <= 1'b0;
         rsp_ovf_ff   <= push_full;
      end else if (fin_pop) begin
         rsp_value_ff <= found_ff ? best_val_ff : '0;
         rsp_list_ff  <= found_ff ? kwm_pkg::SEL_W'(best_idx_ff) : '0;
         rsp_ok_ff    <= found_ff;
         rsp_ovf_ff   <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_list  = rsp_list_ff;
   assign rsp_out_valid = rsp_ok_ff;
   assign rsp_overflow  = rsp_ovf_ff;

`ifndef SYNTH
   // a written pointer entry never holds more than a list can
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      meta_we |-> (meta_wdata[CW-1:0] <= CW'(LIST_DEPTH)))
      else $error("list fill count beyond depth");

   // a popped element never comes with an overflow flag
   a_pop_no_ovf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_valid) |-> !rsp_overflow)
      else $error("pop result carries overflow");

   // the compare stage only runs during a pop
   a_scan_in_pop: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> (state_ff == ST_WAIT || state_ff == ST_SCAN))
      else $error("compare stage active outside a pop");

   // a new result is only produced while a transaction is in flight
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) != ST_IDLE))
      else $error("result without a transaction");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/k_way_sorted_merge_tb.sv =====
// k_way_sorted_merge_tb: self-checking testbench for the k-way sorted merge block
module k_way_sorted_merge_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LISTS          = 8;
   localparam int LIST_DEPTH     = 64;
   localparam int RANDOM_ITEMS   = 1880;
   localparam int SETTLE_CYCLES  = 3 * (LISTS + 4);
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic signed [kwm_pkg::VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;
   localparam logic signed [kwm_pkg::VALUE_W-1:0] VMIN = 32'sh8000_0000;

   // one expected response transaction
   typedef struct {
      logic signed [kwm_pkg::VALUE_W-1:0] value;
      logic [kwm_pkg::SEL_W-1:0]          list;
      logic                               valid;
      logic                               overflow;
   } merge_result_type;

   // mirrors the list fifos and keeps the responses still owed by the block
   class merge_scoreboard_type;
      logic signed [kwm_pkg::VALUE_W-1:0] store [LISTS][LIST_DEPTH];
      int unsigned head [LISTS];
      int unsigned tail [LISTS];
      int unsigned fill [LISTS];
      merge_result_type results_due [$];
      int errors;
      int pushes;
      int drops;
      int pops;
      int empty_pops;
      int tie_picks;

      // predict the response of one accepted request transaction
      function void note_request(logic op, logic [kwm_pkg::SEL_W-1:0] sel,
                                 logic signed [kwm_pkg::VALUE_W-1:0] val);
         merge_result_type r;
         bit found;
         int best;
         logic signed [kwm_pkg::VALUE_W-1:0] best_val;
         logic signed [kwm_pkg::VALUE_W-1:0] v;
         r.value    = '0;
         r.list     = '0;
         r.valid    = 1'b0;
         r.overflow = 1'b0;
         if (op == kwm_pkg::OP_PUSH) begin
            pushes++;
            if (sel >= LISTS || fill[sel] >= LIST_DEPTH) begin
               r.overflow = 1'b1;
               drops++;
            end else begin
               store[sel][tail[sel]] = val;
               tail[sel] = (tail[sel] + 1) % LIST_DEPTH;
               fill[sel]++;
            end
         end else begin
            pops++;
            found    = 1'b0;
            best     = 0;
            best_val = '0;
            // smallest head wins, lower list number on equal heads
            for (int n = 0; n < LISTS; n++) begin
               if (fill[n] != 0) begin
                  v = store[n][head[n]];
                  if (!found || v < best_val) begin
                     found    = 1'b1;
                     best     = n;
                     best_val = v;
                  end else if (v == best_val) begin
                     tie_picks++;
                  end
               end
            end
            if (found) begin
               head[best] = (head[best] + 1) % LIST_DEPTH;
               fill[best]--;
               r.value = best_val;
               r.list  = best[kwm_pkg::SEL_W-1:0];
               r.valid = 1'b1;
            end else begin
               empty_pops++;
            end
         end
         results_due = {results_due, r};
      endfunction

      function void field_error(string name, logic signed [kwm_pkg::VALUE_W-1:0] exp_v,
                                logic signed [kwm_pkg::VALUE_W-1:0] act_v);
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      endfunction

      // compare one accepted response transaction with the oldest prediction
      function void check_response(logic signed [kwm_pkg::VALUE_W-1:0] value,
                                   logic [kwm_pkg::SEL_W-1:0] list,
                                   logic valid, logic overflow);
         merge_result_type e;
         if (results_due.size() == 0) begin
            errors++;
            $display("%0t: response with nothing outstanding, expected none, actual %0d",
                     $time, value);
            return;
         end
         e = results_due.pop_front();
         if (e.value !== value) field_error("out_value", e.value, value);
         if (e.list !== list)
            field_error("out_list", kwm_pkg::VALUE_W'(e.list), kwm_pkg::VALUE_W'(list));
         if (e.valid !== valid)
            field_error("out_valid", kwm_pkg::VALUE_W'(e.valid), kwm_pkg::VALUE_W'(valid));
         if (e.overflow !== overflow)
            field_error("overflow", kwm_pkg::VALUE_W'(e.overflow),
                        kwm_pkg::VALUE_W'(overflow));
      endfunction

      function int pending();
         return results_due.size();
      endfunction
   endclass

   logic                               clock;
   logic                               reset         = 1'b1;
   logic                               req_valid     = 1'b0;
   logic                               req_ready;
   logic                               req_op        = kwm_pkg::OP_PUSH;
   logic [kwm_pkg::SEL_W-1:0]          req_list_sel  = '0;
   logic signed [kwm_pkg::VALUE_W-1:0] req_value     = '0;
   logic                               rsp_valid;
   logic                               rsp_ready     = 1'b0;
   logic signed [kwm_pkg::VALUE_W-1:0] rsp_out_value;
   logic [kwm_pkg::SEL_W-1:0]          rsp_out_list;
   logic                               rsp_out_valid;
   logic                               rsp_overflow;

   merge_scoreboard_type sb;
   bit  steady_flow = 1'b0;
   int  ready_hold  = 0;
   int  quiet_cycles = 0;
   logic signed [kwm_pkg::VALUE_W-1:0] run_tail [LISTS];

   k_way_sorted_merge #(
      .LISTS      (LISTS),
      .LIST_DEPTH (LIST_DEPTH)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_list_sel  (req_list_sel),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_value (rsp_out_value),
      .rsp_out_list  (rsp_out_list),
      .rsp_out_valid (rsp_out_valid),
      .rsp_overflow  (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side backpressure: mostly ready, short stalls, an occasional long one
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (steady_flow) begin
         rsp_ready <= 1'b1;
      end else if (r < 60) begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(0, 4);
      end else if (r < 95) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 3);
      end else begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(10, 40);
      end
   end

   // transaction monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready) sb.note_request(req_op, req_list_sel, req_value);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_out_value, rsp_out_list, rsp_out_valid, rsp_overflow);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
            $display("k_way_sorted_merge_tb NOT OK");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // mostly ascending runs per list, with extremes and unsorted noise mixed in
   function automatic logic signed [kwm_pkg::VALUE_W-1:0] pick_value(
         logic [kwm_pkg::SEL_W-1:0] sel, bit noisy);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) begin
         unique case ($urandom_range(0, 3))
            0:       return VMIN;
            1:       return VMAX;
            2:       return '0;
            default: return -1;
         endcase
      end
      if (noisy || r < 12) return $urandom;
      if (r < 18 || run_tail[sel] > VMAX - 4)
         run_tail[sel] = $signed($urandom_range(0, 64)) - 32;
      else
         run_tail[sel] = run_tail[sel] + $signed($urandom_range(0, 3));
      return run_tail[sel];
   endfunction

   task automatic send_item(logic op, logic [kwm_pkg::SEL_W-1:0] sel,
                            logic signed [kwm_pkg::VALUE_W-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_list_sel <= sel;
      req_value    <= val;
      do @(posedge clock); while (!req_ready);
   endtask

   // pop with random don't-care fields
   task automatic pop_merged();
      send_item(kwm_pkg::OP_POP, kwm_pkg::SEL_W'($urandom_range(0, 7)), $urandom);
   endtask

   // hold the request side off until every outstanding response has come back
   task automatic idle_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      int sent;
      int mode;
      int len;
      int push_pct;
      logic [kwm_pkg::SEL_W-1:0] focus;
      logic [kwm_pkg::SEL_W-1:0] sel;
      sb = new();
      for (int n = 0; n < LISTS; n++) run_tail[n] = $signed($urandom_range(0, 16)) - 8;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pop, extremes, equal heads across lists
      pop_merged();
      send_item(kwm_pkg::OP_PUSH, 3'd0, VMAX);
      send_item(kwm_pkg::OP_PUSH, 3'd7, VMIN);
      send_item(kwm_pkg::OP_PUSH, 3'd3, 32'sd0);
      send_item(kwm_pkg::OP_PUSH, 3'd5, -32'sd1);
      send_item(kwm_pkg::OP_PUSH, 3'd1, 32'sd0);
      send_item(kwm_pkg::OP_PUSH, 3'd6, VMIN);
      repeat (6) pop_merged();
      pop_merged();
      send_item(kwm_pkg::OP_PUSH, 3'd2, 32'sh5555_5555);
      send_item(kwm_pkg::OP_PUSH, 3'd4, 32'shAAAA_AAAA);
      send_item(kwm_pkg::OP_PUSH, 3'd2, 32'sh0000_0001);
      send_item(kwm_pkg::OP_PUSH, 3'd4, -32'sd1);
      repeat (4) pop_merged();
      idle_until_drained();

      // fill one list past its depth, then drain everything and pop once more on empty
      sent  = 0;
      focus = kwm_pkg::SEL_W'($urandom_range(0, 7));
      repeat (LIST_DEPTH + 2) begin
         send_item(kwm_pkg::OP_PUSH, focus, pick_value(focus, 1'b0));
         sent++;
      end
      repeat (LIST_DEPTH + 1) begin
         pop_merged();
         sent++;
      end
      idle_until_drained();

      // random phases: balanced traffic, fill bursts, drain bursts and noise
      while (sent < RANDOM_ITEMS) begin
         mode  = $urandom_range(0, 9);
         len   = $urandom_range(20, 120);
         focus = kwm_pkg::SEL_W'($urandom_range(0, 7));
         steady_flow <= ($urandom_range(0, 3) == 0);
         unique case (mode)
            5, 6:    push_pct = 90;
            7, 8:    push_pct = 20;
            default: push_pct = 55;
         endcase
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < push_pct) begin
               if ((mode == 5 || mode == 6) && $urandom_range(0, 9) != 0)
                  sel = focus;
               else
                  sel = kwm_pkg::SEL_W'($urandom_range(0, 7));
               send_item(kwm_pkg::OP_PUSH, sel, pick_value(sel, mode == 9));
            end else begin
               pop_merged();
            end
            sent++;
         end
         if ($urandom_range(0, 3) == 0) idle_until_drained();
      end

      // wind down and report
      idle_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d pushes (%0d dropped on a full list) and %0d pops", sb.pushes,
               sb.drops, sb.pops);
      $display("pops on all-empty lists %0d, equal-head decisions %0d", sb.empty_pops,
               sb.tie_picks);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("k_way_sorted_merge_tb OK");
      else
         $display("k_way_sorted_merge_tb NOT OK");
      $finish;
   end

endmodule
